// ===== hdl/crl_pkg.sv =====
// Shared constants for the circular array rank list: field widths, modes and status codes.
`timescale 1ns / 1ps
`default_nettype none
package crl_pkg;

	localparam int ITEM_W   = 8;
	localparam int MODE_W   = 3;
	localparam int RANK_W   = 4;
	localparam int SIZE_W   = 4;
	localparam int STATUS_W = 2;

	localparam logic [MODE_W-1:0] MODE_SIZE   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_GET    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SET    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ADD    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_RANK  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd3;

endpackage
`default_nettype wire

// ===== hdl/crl_ring_ram.sv =====
// Ring storage: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none
module crl_ring_ram
	import crl_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [ITEM_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [AW-1:0]     raddr,
	output logic      [ITEM_W-1:0] rdata
);

	logic [ITEM_W-1:0] ram_q [DEPTH];
	logic [ITEM_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			ram_q[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= ram_q[raddr];
		end
	end

	assign rdata = rd_data_q;

endmodule
`default_nettype wire

// ===== hdl/circular_array_rank_list_core.sv =====
// Top level of the circular array rank list: command decode, shift sequencer and ring state.
//
// A ranked list of bytes kept in a ring of SLOTS entries (at most SLOTS-1 items).
// A command is taken when start is high and busy is low. Its single result appears
// on item_out, list_size and status for exactly one cycle with done high, and the
// receiver cannot hold it off. Size requests, errors and set give the result the
// cycle after the command. A get registers the read data in S_GET. Add and remove
// shift the shorter side of the list by one slot, one item at a time through the
// ring memory (a read in S_RD, then a write in S_WR of the data read back). A
// remove first captures its item in S_TAKE; both end in S_FIN, which writes the
// new byte of an add and updates the count. busy stays high until the cycle in
// which the result is out. list_size reports the low 4 bits of the item count.
// Slots of the ring are never cleared; only slots holding items are read.
`timescale 1ns / 1ps
`default_nettype none
module circular_array_rank_list_core
	import crl_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [MODE_W-1:0]   mode,
	input  wire logic [RANK_W-1:0]   rank,
	input  wire logic [ITEM_W-1:0]   item_in,
	output logic                     done,
	output logic      [ITEM_W-1:0]   item_out,
	output logic      [SIZE_W-1:0]   list_size,
	output logic      [STATUS_W-1:0] status
);

	localparam int CW = $clog2(SLOTS);
	localparam int MW = (CW > RANK_W) ? CW : RANK_W;
	localparam int SW = MW + 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_GET  = 3'd1;
	localparam logic [2:0] S_TAKE = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_WR   = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	function automatic logic [CW-1:0] ring_inc(input logic [CW-1:0] a);
		return (a == CW'(SLOTS - 1)) ? '0 : a + 1'b1;
	endfunction

	function automatic logic [CW-1:0] ring_dec(input logic [CW-1:0] a);
		return (a == '0) ? CW'(SLOTS - 1) : a - 1'b1;
	endfunction

	logic [2:0]        state_q;
	logic [CW-1:0]     front_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     src_q;
	logic [CW-1:0]     moves_q;
	logic              up_q;
	logic [CW-1:0]     fin_addr_q;
	logic [ITEM_W-1:0] item_q;
	logic              is_add_q;
	logic              front_side_q;
	logic              done_q;
	logic [ITEM_W-1:0] item_out_q;
	logic [STATUS_W-1:0] status_q;

	logic              accept;
	logic [MW-1:0]     rank_ext;
	logic [MW-1:0]     n_ext;
	logic [SW-1:0]     pr_sum;
	logic [SW-1:0]     pn_sum;
	logic [CW-1:0]     pr;
	logic [CW-1:0]     pn;
	logic              full;
	logic              empty;
	logic              rank_bad;
	logic              rank_bad_add;
	logic              front_side;
	logic [CW-1:0]     dst;

	logic              mem_we;
	logic [CW-1:0]     mem_waddr;
	logic [ITEM_W-1:0] mem_wdata;
	logic              mem_re;
	logic [CW-1:0]     mem_raddr;
	logic [ITEM_W-1:0] mem_rdata;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	assign rank_ext = MW'(rank);
	assign n_ext    = MW'(count_q);

	// ring slots of rank r and of rank n (one past the back)
	assign pr_sum = SW'(front_q) + SW'(rank);
	assign pn_sum = SW'(front_q) + SW'(count_q);
	assign pr = (pr_sum >= SW'(SLOTS)) ? CW'(pr_sum - SW'(SLOTS)) : CW'(pr_sum);
	assign pn = (pn_sum >= SW'(SLOTS)) ? CW'(pn_sum - SW'(SLOTS)) : CW'(pn_sum);

	assign full         = (count_q == CW'(SLOTS - 1));
	assign empty        = (count_q == '0);
	assign rank_bad     = (rank_ext >= n_ext);
	assign rank_bad_add = (rank_ext > n_ext);
	assign front_side   = (rank_ext < (n_ext >> 1));

	// up: item moves one slot toward the front
	assign dst = up_q ? ring_dec(src_q) : ring_inc(src_q);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = dst;
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = src_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					mem_raddr = pr;
					mem_waddr = pr;
					mem_wdata = item_in;
					if (mode == MODE_SET && !rank_bad) begin
						mem_we = 1'b1;
					end
					if ((mode == MODE_GET && !rank_bad) ||
					    (mode == MODE_REMOVE && !empty && !rank_bad)) begin
						mem_re = 1'b1;
					end
				end
			end
			S_RD: begin
				mem_re = 1'b1;
			end
			S_WR: begin
				mem_we = 1'b1;
			end
			S_FIN: begin
				mem_we    = is_add_q;
				mem_waddr = fin_addr_q;
				mem_wdata = item_q;
			end
			default: begin
			end
		endcase
	end

	crl_ring_ram #(
		.DEPTH(SLOTS),
		.AW   (CW)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			front_q <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (mode)
							MODE_GET: begin
								if (rank_bad) begin
									done_q <= 1'b1;
								end else begin
									state_q <= S_GET;
								end
							end
							MODE_SET: begin
								done_q <= 1'b1;
							end
							MODE_ADD: begin
								if (full || rank_bad_add) begin
									done_q <= 1'b1;
								end else if (front_side && rank_ext == '0) begin
									state_q <= S_FIN;
								end else if (!front_side && rank_ext == n_ext) begin
									state_q <= S_FIN;
								end else begin
									state_q <= S_RD;
								end
							end
							MODE_REMOVE: begin
								if (empty || rank_bad) begin
									done_q <= 1'b1;
								end else begin
									state_q <= S_TAKE;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_GET: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_TAKE: begin
					state_q <= (moves_q == '0) ? S_FIN : S_RD;
				end
				S_RD: begin
					state_q <= S_WR;
				end
				S_WR: begin
					state_q <= (moves_q == CW'(1)) ? S_FIN : S_RD;
				end
				S_FIN: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (is_add_q) begin
						count_q <= count_q + 1'b1;
						if (front_side_q) begin
							front_q <= ring_dec(front_q);
						end
					end else begin
						count_q <= count_q - 1'b1;
						if (front_side_q) begin
							front_q <= ring_inc(front_q);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// sequencer payload and result fields
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					item_q       <= item_in;
					is_add_q     <= (mode == MODE_ADD);
					front_side_q <= front_side;
					item_out_q   <= '0;
					status_q     <= STAT_OK;
					case (mode)
						MODE_GET: begin
							if (rank_bad) begin
								status_q <= STAT_RANK;
							end
						end
						MODE_SET: begin
							if (rank_bad) begin
								status_q <= STAT_RANK;
							end else begin
								item_out_q <= item_in;
							end
						end
						MODE_ADD: begin
							if (full) begin
								status_q <= STAT_FULL;
							end else if (rank_bad_add) begin
								status_q <= STAT_RANK;
							end
							if (front_side) begin
								// ranks 0..r-1 move toward the front, new byte lands before rank r
								up_q       <= 1'b1;
								src_q      <= front_q;
								moves_q    <= CW'(rank_ext);
								fin_addr_q <= ring_dec(pr);
							end else begin
								// ranks n-1 down to r move toward the back
								up_q       <= 1'b0;
								src_q      <= ring_dec(pn);
								moves_q    <= CW'(n_ext - rank_ext);
								fin_addr_q <= pr;
							end
						end
						MODE_REMOVE: begin
							if (empty) begin
								status_q <= STAT_EMPTY;
							end else if (rank_bad) begin
								status_q <= STAT_RANK;
							end
							if (front_side) begin
								up_q    <= 1'b0;
								src_q   <= ring_dec(pr);
								moves_q <= CW'(rank_ext);
							end else begin
								up_q    <= 1'b1;
								src_q   <= ring_inc(pr);
								moves_q <= CW'(n_ext - rank_ext - MW'(1));
							end
							fin_addr_q <= pr;
						end
						default: begin
						end
					endcase
				end
			end
			S_GET: begin
				item_out_q <= mem_rdata;
			end
			S_TAKE: begin
				item_out_q <= mem_rdata;
			end
			S_WR: begin
				moves_q <= moves_q - 1'b1;
				src_q   <= up_q ? ring_inc(src_q) : ring_dec(src_q);
			end
			default: begin
			end
		endcase
	end

	logic [MW-1:0] count_ext;
	assign count_ext = MW'(count_q);

	assign done      = done_q;
	assign item_out  = item_out_q;
	assign status    = status_q;
	assign list_size = count_ext[SIZE_W-1:0];

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for circular_array_rank_list_core: command driver, result monitor and scoreboard.
`timescale 1ns / 1ps

import crl_pkg::*;

typedef struct {
	logic [ITEM_W-1:0]   item;
	logic [SIZE_W-1:0]   size;
	logic [STATUS_W-1:0] status;
} reply_t;

class reply_scoreboard;
	localparam int SLOTS = 16;

	bit [ITEM_W-1:0] ring [SLOTS];
	int front;
	int count;
	reply_t pending_replies [$];
	int errors;
	int checked;
	int status_seen [4];

	function new();
		front = 0;
		count = 0;
		errors = 0;
		checked = 0;
		foreach (status_seen[k]) status_seen[k] = 0;
	endfunction

	// ring index of rank pos; pos may be -1
	function int slot(int pos);
		return (front + pos + SLOTS) % SLOTS;
	endfunction

	// Work out the reply of one accepted command and apply it to the list.
	function void note_command(logic [MODE_W-1:0] m, logic [RANK_W-1:0] r,
			logic [ITEM_W-1:0] e);
		reply_t exp;
		int n;
		int rk;
		exp.item = '0;
		exp.status = STAT_OK;
		n = count;
		rk = r;
		case (m)
			MODE_GET: begin
				if (rk >= n) exp.status = STAT_RANK;
				else exp.item = ring[slot(rk)];
			end
			MODE_SET: begin
				if (rk >= n) begin
					exp.status = STAT_RANK;
				end else begin
					ring[slot(rk)] = e;
					exp.item = e;
				end
			end
			MODE_ADD: begin
				if (n >= SLOTS - 1) begin
					exp.status = STAT_FULL;
				end else if (rk > n) begin
					exp.status = STAT_RANK;
				end else begin
					if (rk < n / 2) begin
						// front half slides one slot toward the front
						for (int i = 0; i < rk; i++) ring[slot(i - 1)] = ring[slot(i)];
						ring[slot(rk - 1)] = e;
						front = (front + SLOTS - 1) % SLOTS;
					end else begin
						for (int i = n; i > rk; i--) ring[slot(i)] = ring[slot(i - 1)];
						ring[slot(rk)] = e;
					end
					count = n + 1;
				end
			end
			MODE_REMOVE: begin
				if (n == 0) begin
					exp.status = STAT_EMPTY;
				end else if (rk >= n) begin
					exp.status = STAT_RANK;
				end else begin
					exp.item = ring[slot(rk)];
					if (rk < n / 2) begin
						for (int i = rk; i > 0; i--) ring[slot(i)] = ring[slot(i - 1)];
						front = (front + 1) % SLOTS;
					end else begin
						for (int i = rk + 1; i < n; i++) ring[slot(i - 1)] = ring[slot(i)];
					end
					count = n - 1;
				end
			end
			default: ;	// size request and undefined modes
		endcase
		exp.size = count[SIZE_W-1:0];
		status_seen[exp.status]++;
		pending_replies.push_back(exp);
	endfunction

	function void check_reply(logic [ITEM_W-1:0] item, logic [SIZE_W-1:0] size,
			logic [STATUS_W-1:0] st);
		reply_t exp;
		if (pending_replies.size() == 0) begin
			$error("result with no command outstanding: item_out %0d list_size %0d status %0d",
				item, size, st);
			errors++;
			return;
		end
		exp = pending_replies.pop_front();
		checked++;
		if (item !== exp.item) begin
			$error("item_out: expected %0d, got %0d", exp.item, item);
			errors++;
		end
		if (size !== exp.size) begin
			$error("list_size: expected %0d, got %0d", exp.size, size);
			errors++;
		end
		if (st !== exp.status) begin
			$error("status: expected %0d, got %0d", exp.status, st);
			errors++;
		end
	endfunction
endclass

module tb_top;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_CMDS = 1600;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [MODE_W-1:0]   mode;
	logic [RANK_W-1:0]   rank;
	logic [ITEM_W-1:0]   item_in;
	logic                done;
	logic [ITEM_W-1:0]   item_out;
	logic [SIZE_W-1:0]   list_size;
	logic [STATUS_W-1:0] status;

	reply_scoreboard sb;
	bit idle_on;
	int transfers = 0;
	int stall = 0;

	circular_array_rank_list_core #(.SLOTS(16)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.rank(rank),
		.item_in(item_in),
		.done(done),
		.item_out(item_out),
		.list_size(list_size),
		.status(status)
	);

	always #5 clk = ~clk;

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic issue_cmd(logic [MODE_W-1:0] m, logic [RANK_W-1:0] r,
			logic [ITEM_W-1:0] e);
		if (idle_on && $urandom_range(99) < 22) begin
			start = 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		start = 1'b1;
		mode = m;
		rank = r;
		item_in = e;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) sb.check_reply(item_out, list_size, status);
			if (start && !busy) begin
				sb.note_command(mode, rank, item_in);
				transfers++;
				stall = 0;
			end else if (done) begin
				stall = 0;
			end else begin
				stall++;
			end
			if (stall >= STALL_LIMIT) begin
				$display("watchdog: no transfer or result for %0d cycles", STALL_LIMIT);
				$display("tb_top: done, errors");
				$finish;
			end
		end
	end

	initial begin
		int n;
		int pick;
		bit growing;
		logic [MODE_W-1:0] m;
		logic [RANK_W-1:0] r;
		logic [ITEM_W-1:0] e;

		sb = new();
		start = 1'b0;
		mode = MODE_SIZE;
		rank = '0;
		item_in = '0;
		arst_n = 1'b0;
		idle_on = 1'b1;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty-list errors, fill to capacity, full-list and edge ranks
		issue_cmd(MODE_SIZE, 4'd0, 8'd0);
		issue_cmd(MODE_GET, 4'd0, 8'd0);
		issue_cmd(MODE_SET, 4'd0, 8'hA5);
		issue_cmd(MODE_REMOVE, 4'd0, 8'd0);
		issue_cmd(MODE_REMOVE, 4'd15, 8'd0);	// empty wins over bad rank
		issue_cmd(MODE_ADD, 4'd1, 8'h11);
		issue_cmd(MODE_ADD, 4'd0, 8'hFF);
		for (int k = 0; k < 14; k++) begin
			n = sb.count;
			case (k % 3)
				0: r = '0;
				1: r = n[RANK_W-1:0];
				default: r = RANK_W'(n / 2);
			endcase
			issue_cmd(MODE_ADD, r, ITEM_W'($urandom_range(255)));
		end
		issue_cmd(MODE_ADD, 4'd15, 8'h5A);	// full list, with rank 15 still in range
		issue_cmd(MODE_GET, 4'd14, 8'd0);
		issue_cmd(MODE_GET, 4'd15, 8'd0);
		issue_cmd(MODE_SET, 4'd0, 8'h00);
		issue_cmd(MODE_REMOVE, 4'd15, 8'd0);
		issue_cmd(3'd7, 4'd3, 8'hFF);
		issue_cmd(MODE_REMOVE, 4'd7, 8'd0);

		growing = 1'b0;
		for (int i = 0; i < RANDOM_CMDS; i++) begin
			idle_on = !(i >= 500 && i < 900);
			n = sb.count;
			if (n >= 15) growing = 1'b0;
			else if (n == 0) growing = 1'b1;
			pick = $urandom_range(99);
			if (pick < 4) m = MODE_W'($urandom_range(7, 5));
			else if (pick < 12) m = MODE_SIZE;
			else if (pick < 26) m = MODE_GET;
			else if (pick < 40) m = MODE_SET;
			else if (pick < 80) m = growing ? MODE_ADD : MODE_REMOVE;
			else m = growing ? MODE_REMOVE : MODE_ADD;
			if ($urandom_range(99) < 12) r = RANK_W'($urandom_range(15));
			else if (m == MODE_ADD) r = RANK_W'($urandom_range(n));
			else r = (n > 0) ? RANK_W'($urandom_range(n - 1)) : '0;
			pick = $urandom_range(99);
			if (pick < 10) e = '0;
			else if (pick < 20) e = '1;
			else e = ITEM_W'($urandom_range(255));
			issue_cmd(m, r, e);
		end
		start = 1'b0;

		while (sb.pending_replies.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("covered %0d command transfers, %0d results compared", transfers, sb.checked);
		$display("status mix: ok %0d, bad rank %0d, full %0d, empty %0d",
			sb.status_seen[STAT_OK], sb.status_seen[STAT_RANK],
			sb.status_seen[STAT_FULL], sb.status_seen[STAT_EMPTY]);
		if (sb.errors == 0 && sb.pending_replies.size() == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end
endmodule
